>>> src/multi_channel_interval_timer_defines.svh
// Assertion macros for the timer bank checker.
`ifndef MULTI_CHANNEL_INTERVAL_TIMER_DEFINES_SVH
`define MULTI_CHANNEL_INTERVAL_TIMER_DEFINES_SVH

// Checked at every edge outside reset.
`define MCIT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define MCIT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/mcit_pkg.sv
// Types and constants of the interval timer bank.
package mcit_pkg;

  localparam int IDX_W = 4;
  localparam int CNT_W = 16;

  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_ENABLE  = 2'd1;
  localparam logic [1:0] CMD_DISABLE = 2'd2;
  localparam logic [1:0] CMD_RESET   = 2'd3;

  typedef struct packed {
    logic [1:0]       command;
    logic [IDX_W-1:0] timer_index;
    logic             repeat_mode;
    logic [CNT_W-1:0] interval;
  } cmd_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] expired_index;
    logic             last_expiry;
  } expiry_item_t;

  typedef struct packed {
    logic             step;
    logic [IDX_W-1:0] idx;
  } walk_ctrl_t;

  typedef struct packed {
    logic fire;
  } walk_stat_t;

endpackage

>>> src/mcit_bank.sv
// Timer state storage with the shared increment and compare unit.
module mcit_bank #(
  parameter int NUM_TIMERS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_we,
  input  mcit_pkg::cmd_item_t cmd,
  input  mcit_pkg::walk_ctrl_t walk,
  output mcit_pkg::walk_stat_t stat
);
  import mcit_pkg::*;

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  logic [NUM_TIMERS-1:0] enable_mask;
  logic [CNT_W-1:0]      tick_counters [NUM_TIMERS];
  logic [CNT_W-1:0]      period_store [NUM_TIMERS];
  logic                  auto_reload_flags [NUM_TIMERS];

  logic [IW-1:0]    widx;
  logic [IW-1:0]    cidx;
  logic             cmd_in_range;
  logic [CNT_W-1:0] cnt_inc;
  logic             fire;

  assign widx = walk.idx[IW-1:0];
  assign cidx = cmd.timer_index[IW-1:0];
  assign cmd_in_range = ({1'b0, cmd.timer_index} < (IDX_W + 1)'(NUM_TIMERS));

  assign cnt_inc = (tick_counters[widx] == {CNT_W{1'b1}}) ? tick_counters[widx]
                                                          : tick_counters[widx] + 1'b1;
  assign fire = enable_mask[widx] && (cnt_inc >= period_store[widx]);

  assign stat.fire = fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask <= '0;
    end else if (cmd_we && cmd_in_range) begin
      case (cmd.command)
        CMD_ENABLE:  enable_mask[cidx] <= 1'b1;
        CMD_DISABLE: enable_mask[cidx] <= 1'b0;
        default:     ;
      endcase
    end else if (walk.step && fire && !auto_reload_flags[widx]) begin
      enable_mask[widx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_we && cmd_in_range) begin
      case (cmd.command)
        CMD_ENABLE: begin
          tick_counters[cidx]     <= '0;
          period_store[cidx]      <= cmd.interval;
          auto_reload_flags[cidx] <= cmd.repeat_mode;
        end
        CMD_RESET: tick_counters[cidx] <= '0;
        default:   ;
      endcase
    end else if (walk.step && enable_mask[widx]) begin
      tick_counters[widx] <= (fire && auto_reload_flags[widx]) ? '0 : cnt_inc;
    end
  end

endmodule

>>> src/mcit_seq.sv
// Tick walk sequencer with pending and output result registers.
module mcit_seq #(
  parameter int NUM_TIMERS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  mcit_pkg::cmd_item_t    cmd,
  output mcit_pkg::walk_ctrl_t   walk,
  input  mcit_pkg::walk_stat_t   stat,
  output logic                   expiry_valid,
  input  logic                   expiry_ready,
  output mcit_pkg::expiry_item_t expiry
);
  import mcit_pkg::*;

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t        state, state_next;
  logic [IW-1:0] k, k_next;
  logic          pend_valid, pend_valid_next;
  logic [IW-1:0] pend_idx, pend_idx_next;
  logic          push;
  expiry_item_t  push_data;
  logic          slot_free;
  logic          stall;
  logic          last_k;

  assign slot_free = !expiry_valid || expiry_ready;
  assign last_k    = (k == IW'(NUM_TIMERS - 1));
  assign cmd_ready = (state == ST_IDLE);
  assign stall     = stat.fire && pend_valid && !slot_free;
  assign walk.step = (state == ST_WALK) && !stall;
  assign walk.idx  = IDX_W'(k);

  always_comb begin
    state_next      = state;
    k_next          = k;
    pend_valid_next = pend_valid;
    pend_idx_next   = pend_idx;
    push            = 1'b0;
    push_data.expired_index = IDX_W'(pend_idx);
    push_data.last_expiry   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid && cmd.command == CMD_TICK) begin
          state_next = ST_WALK;
          k_next     = '0;
        end
      end
      ST_WALK: begin
        if (!stall) begin
          if (stat.fire) begin
            push            = pend_valid;
            pend_valid_next = 1'b1;
            pend_idx_next   = k;
          end
          if (last_k) begin
            state_next = ST_FLUSH;
          end else begin
            k_next = k + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (slot_free) begin
          push                  = 1'b1;
          push_data.last_expiry = 1'b1;
          pend_valid_next       = 1'b0;
          state_next            = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      k            <= '0;
      pend_valid   <= 1'b0;
      expiry_valid <= 1'b0;
    end else begin
      state      <= state_next;
      k          <= k_next;
      pend_valid <= pend_valid_next;
      if (push) begin
        expiry_valid <= 1'b1;
      end else if (expiry_ready) begin
        expiry_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx <= pend_idx_next;
    if (push) begin
      expiry <= push_data;
    end
  end

endmodule

>>> src/multi_channel_interval_timer.sv
// Top level of the interval timer bank.
// Enable, disable and counter reset items give no result. A tick item walks the timers one
// per cycle, unless a full output register stalls the walk, through one shared compare unit;
// cmd_ready stays low until the walk and its flush are done. Each result waits until the next
// timer fires or the walk ends; the last one leaves from the flush state, marked last_expiry.
// Reset turns every timer off and empties the result registers; enable loads the rest.
module multi_channel_interval_timer #(
  parameter int NUM_TIMERS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  mcit_pkg::cmd_item_t    cmd,
  output logic                   expiry_valid,
  input  logic                   expiry_ready,
  output mcit_pkg::expiry_item_t expiry
);
  import mcit_pkg::*;

  walk_ctrl_t walk;
  walk_stat_t stat;
  logic       cmd_we;

  assign cmd_we = cmd_valid && cmd_ready && (cmd.command != CMD_TICK);

  mcit_bank #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_bank (
    .clk    (clk),
    .rst    (rst),
    .cmd_we (cmd_we),
    .cmd    (cmd),
    .walk   (walk),
    .stat   (stat)
  );

  mcit_seq #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .walk         (walk),
    .stat         (stat),
    .expiry_valid (expiry_valid),
    .expiry_ready (expiry_ready),
    .expiry       (expiry)
  );

endmodule

>>> src/mcit_checker.sv
// Port-level checks of the interval timer bank and their binding.
`include "multi_channel_interval_timer_defines.svh"

module mcit_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   cmd_valid,
  input logic                   cmd_ready,
  input mcit_pkg::cmd_item_t    cmd,
  input logic                   expiry_valid,
  input logic                   expiry_ready,
  input mcit_pkg::expiry_item_t expiry
);
  import mcit_pkg::*;

  `MCIT_ASSERT(a_expiry_hold, expiry_valid && !expiry_ready |=> expiry_valid && $stable(expiry), "expiry item changed while stalled")
  `MCIT_ASSERT(a_tick_busy, cmd_valid && cmd_ready && cmd.command == CMD_TICK |=> !cmd_ready, "ready right after a tick")
  `MCIT_ASSERT(a_cmd_silent, cmd_valid && cmd_ready && cmd.command != CMD_TICK && !expiry_valid |=> !expiry_valid, "result after a non-tick item")
  `MCIT_ASSERT_ALWAYS(a_reset_empty, rst |=> !expiry_valid, "result valid after reset")

endmodule

bind multi_channel_interval_timer mcit_checker u_chk (.*);
